FILE: hw/rtl/uhir_pkg.sv
// Package for the UDP header insertion and realignment block.
// Holds command codes, header constants, the queue entry type and byte helpers.
// No dependencies.
package uhir_pkg;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Protocol number 17 (UDP) as it sits in the pseudo-header word, byte swapped.
  localparam logic [15:0] PROTO_WORD = 16'h1100;
  localparam logic [15:0] HDR_BYTES  = 16'd8;
  localparam logic [15:0] HALF_BYTES = 16'd4;
  localparam logic [7:0]  KEEP_ALL   = 8'hFF;
  localparam logic [3:0]  KEEP_LOW   = 4'hF;

  // One classified item: one or two stream words to send.
  typedef struct packed {
    logic [63:0] data0;
    logic [7:0]  keep0;
    logic        last0;
    logic        two;
    logic [63:0] data1;
    logic [7:0]  keep1;
    logic        last1;
  } op_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [15:0] bswap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  // Mask with the low n bits set, n from 0 to 4.
  function automatic logic [3:0] low_mask4(input logic [2:0] n);
    logic [3:0] m;
    case (n)
      3'd0:    m = 4'h0;
      3'd1:    m = 4'h1;
      3'd2:    m = 4'h3;
      3'd3:    m = 4'h7;
      default: m = 4'hF;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/uhir_if.sv
// Stream interfaces of the UDP header insertion block: request and word channels.
// Depends on nothing; valid/ready handshake on each.
interface uhir_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] ip_src;
  logic [31:0] ip_dst;
  logic [15:0] udp_sport;
  logic [15:0] udp_dport;
  logic [15:0] payload_length;
  logic [63:0] payload_data;

  modport source (
    output valid, cmd, ip_src, ip_dst, udp_sport, udp_dport, payload_length,
           payload_data,
    input  ready
  );
  modport sink (
    input  valid, cmd, ip_src, ip_dst, udp_sport, udp_dport, payload_length,
           payload_data,
    output ready
  );
endinterface

interface uhir_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [7:0]  out_keep;
  logic        out_last;

  modport source (output valid, out_data, out_keep, out_last, input ready);
  modport sink (input valid, out_data, out_keep, out_last, output ready);
endinterface

FILE: hw/rtl/uhir_front.sv
// Front end: accepts requests, tracks packet state and builds the words to send.
// Depends on uhir_pkg and uhir_in_if.
module uhir_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  uhir_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output uhir_pkg::op_t   op_o
);

  logic        in_packet_q, in_packet_d;
  logic [31:0] held_q, held_d;
  logic [15:0] left_q, left_d;
  logic        accept;
  logic        emit;
  logic [15:0] udp_len;
  logic [2:0]  res_n;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign udp_len    = in_i.payload_length + uhir_pkg::HDR_BYTES;
  // Residue byte count when between five and eight bytes remain.
  assign res_n      = left_q[2:0] - uhir_pkg::HALF_BYTES[2:0];

  always_comb begin
    in_packet_d = in_packet_q;
    held_d      = held_q;
    left_d      = left_q;
    emit        = 1'b0;
    op_o        = '0;
    if (in_i.cmd == uhir_pkg::CMD_START) begin
      op_o.data0 = {uhir_pkg::bswap32(in_i.ip_src), uhir_pkg::bswap16(udp_len),
                    uhir_pkg::PROTO_WORD};
      op_o.keep0 = uhir_pkg::KEEP_ALL;
      op_o.two   = 1'b1;
      op_o.data1 = {uhir_pkg::bswap16(in_i.udp_dport), uhir_pkg::bswap16(in_i.udp_sport),
                    uhir_pkg::bswap32(in_i.ip_dst)};
      op_o.keep1 = uhir_pkg::KEEP_ALL;
      if (accept && !in_packet_q) begin
        emit        = 1'b1;
        in_packet_d = 1'b1;
        held_d      = {16'h0000, uhir_pkg::bswap16(udp_len)};
        left_d      = udp_len - uhir_pkg::HDR_BYTES;
      end
    end else begin
      op_o.data0 = {in_i.payload_data[31:0], held_q};
      op_o.data1 = {32'h0, in_i.payload_data[63:32]};
      if (left_q > uhir_pkg::HDR_BYTES) begin
        op_o.keep0 = uhir_pkg::KEEP_ALL;
      end else if (left_q > uhir_pkg::HALF_BYTES) begin
        op_o.keep0 = uhir_pkg::KEEP_ALL;
        op_o.two   = 1'b1;
        op_o.keep1 = {4'h0, uhir_pkg::low_mask4(res_n)};
        op_o.last1 = 1'b1;
      end else begin
        op_o.keep0 = {uhir_pkg::low_mask4(left_q[2:0]), uhir_pkg::KEEP_LOW};
        op_o.last0 = 1'b1;
      end
      if (accept && in_packet_q) begin
        emit   = 1'b1;
        held_d = in_i.payload_data[63:32];
        if (left_q > uhir_pkg::HDR_BYTES) begin
          left_d = left_q - uhir_pkg::HDR_BYTES;
        end else begin
          left_d      = '0;
          in_packet_d = 1'b0;
        end
      end
    end
  end

  assign push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      held_q      <= '0;
      left_q      <= '0;
    end else begin
      in_packet_q <= in_packet_d;
      held_q      <= held_d;
      left_q      <= left_d;
    end
  end

endmodule

FILE: hw/rtl/uhir_queue.sv
// Small FIFO of classified operations between the front and back ends.
// Depends on uhir_pkg.
module uhir_queue #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uhir_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output uhir_pkg::op_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  uhir_pkg::op_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/uhir_back.sv
// Back end: sends the one or two words of each queued operation through an
// output register. Depends on uhir_pkg and uhir_out_if.
module uhir_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  uhir_pkg::op_t head_i,
  output logic          pop_o,
  uhir_out_if.source    out_o
);

  logic        valid_q, valid_d;
  logic        second_q, second_d;
  logic [63:0] data_q, data_d;
  logic [7:0]  keep_q, keep_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !valid_q || out_o.ready;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    data_d   = data_q;
    keep_d   = keep_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (second_q) begin
          data_d   = head_i.data1;
          keep_d   = head_i.keep1;
          last_d   = head_i.last1;
          second_d = 1'b0;
          pop_o    = 1'b1;
        end else begin
          data_d   = head_i.data0;
          keep_d   = head_i.keep0;
          last_d   = head_i.last0;
          second_d = head_i.two;
          pop_o    = !head_i.two;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    keep_q <= keep_d;
    last_q <= last_d;
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_data = data_q;
  assign out_o.out_keep = keep_q;
  assign out_o.out_last = last_q;

endmodule

FILE: hw/rtl/udp_header_insert_realign_top.sv
// A result word passes through the queue and the output register before it is valid
// on out_o; the second word of a two-word request follows it.
// Throughput: one request per cycle, one output word per cycle, while the queue has
// room and out_o is ready; header starts and final residues need a second output word.
// Reset (rst_ni, asynchronous, active low) empties the queue and returns to idle.
module udp_header_insert_realign_top #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uhir_in_if.sink    in_i,
  uhir_out_if.source out_o
);

  // The front end owns the packet state: whether a packet is open, the four
  // bytes carried into the next word, and the payload bytes still expected.
  // Each accepted transaction is classified there into a queue entry holding
  // the complete word or words it produces. Out-of-place requests (a start
  // inside a packet, a payload word outside one) leave no entry.
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  uhir_pkg::op_t push_op;
  uhir_pkg::op_t head_op;

  uhir_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  // The queue decouples the two halves, so the input keeps flowing while the
  // back end sends the second word of a two-word entry.
  uhir_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head_op)
  );

  // The back end walks each entry word by word into the output register and
  // retires the entry once its last word has been loaded.
  uhir_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
